### sv/pidcu_pkg.sv
// Shared types, constants and arithmetic helpers of the PID update core.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package pidcu_pkg;

	localparam int DataW = 32;
	localparam int NumRegs = 8;
	localparam int CfgIdxW = $clog2(NumRegs);
	localparam int FracW = 16;
	localparam int ProdW = 2 * DataW;
	localparam int ShProdW = ProdW - FracW;
	localparam int SumW = ShProdW + 2;

	typedef logic signed [DataW-1:0] data_t;
	typedef logic signed [SumW-1:0] sum_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t RegKp = 3'd0;
	localparam cfg_idx_t RegIntegralGain = 3'd1;
	localparam cfg_idx_t RegDerivGain = 3'd2;
	localparam cfg_idx_t RegDerivDecay = 3'd3;
	localparam cfg_idx_t RegOutMin = 3'd4;
	localparam cfg_idx_t RegOutMax = 3'd5;
	localparam cfg_idx_t RegIntMin = 3'd6;
	localparam cfg_idx_t RegIntMax = 3'd7;

	localparam data_t KpReset = 32'sd1310720;
	localparam data_t IntegralGainReset = 32'sd16384;
	localparam data_t DerivGainReset = 32'sd31508;
	localparam data_t DerivDecayReset = -32'sd60495;
	localparam data_t OutMinReset = 32'sd0;
	localparam data_t OutMaxReset = 32'sd6553600;
	localparam data_t IntMinReset = -32'sd327680;
	localparam data_t IntMaxReset = 32'sd327680;

	localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};
	localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};

	function automatic sum_t sext_data(input data_t x);
		return {{(SumW-DataW){x[DataW-1]}}, x};
	endfunction

	// Product shifted right by the fraction width, which floors toward minus infinity.
	function automatic sum_t sext_shprod(input prod_t p);
		return {{(SumW-ShProdW){p[ProdW-1]}}, p[ProdW-1:FracW]};
	endfunction

	function automatic data_t sat_data(input sum_t v);
		data_t r;
		if (v > sext_data(DataMax)) begin
			r = DataMax;
		end else if (v < sext_data(DataMin)) begin
			r = DataMin;
		end else begin
			r = v[DataW-1:0];
		end
		return r;
	endfunction

	// The upper limit is tested first, so with inverted limits every value
	// lands on one of the two limits.
	function automatic data_t clamp_data(input data_t v, input data_t lo, input data_t hi);
		data_t r;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/pidcu_if.sv
// Valid/ready channel interfaces of the PID update core: one for the
// setpoint and measurement items, one for the drive results. Uses pidcu_pkg.
`default_nettype none

interface pidcu_upd_if;
	logic valid;
	logic ready;
	pidcu_pkg::data_t target;
	pidcu_pkg::data_t sample;

	modport source (output valid, output target, output sample, input ready);
	modport sink (input valid, input target, input sample, output ready);
endinterface

interface pidcu_res_if;
	logic valid;
	logic ready;
	pidcu_pkg::data_t drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

### sv/pid_controller_update_core.sv
// PID update core: an accepted item is held in the input register until the
// output register is empty or being emptied; then its result is loaded into
// the output register. Throughput is one item per cycle while the output is not
// stalled, set by the controller state that is updated in the same cycle as the
// four multiplies of an item. The asynchronous active-low reset loads the gain
// and limit registers with their defaults and clears the controller state.
`default_nettype none

module pid_controller_update_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	pidcu_upd_if.sink                upd,
	pidcu_res_if.source              res,
	input  wire logic                cfg_we,
	input  wire pidcu_pkg::cfg_idx_t cfg_index,
	input  wire pidcu_pkg::data_t    cfg_data
);

	pidcu_pkg::data_t kp_q, ig_q, dg_q, dd_q;
	pidcu_pkg::data_t out_min_q, out_max_q, int_min_q, int_max_q;
	pidcu_pkg::data_t integ_q, last_err_q, deriv_q, last_sample_q;

	logic valid_s1;
	pidcu_pkg::data_t target_s1, sample_s1;
	logic valid_s2;
	pidcu_pkg::data_t drive_s2;

	logic adv;
	pidcu_pkg::data_t err, esum, integ_sat, integ_new, dmeas, diff, raw;
	pidcu_pkg::prod_t p_kp, p_ig, p_dg, p_dd;
	pidcu_pkg::sum_t integ_sum, diff_sum, raw_sum;

	// Stage 1 moves on whenever the output register is empty or being emptied.
	assign adv = valid_s1 && (!valid_s2 || res.ready);
	assign upd.ready = !valid_s1 || adv;
	assign res.valid = valid_s2;
	assign res.drive = drive_s2;

	always_comb begin
		err = pidcu_pkg::sat_data(pidcu_pkg::sext_data(target_s1)
			- pidcu_pkg::sext_data(sample_s1));
		esum = pidcu_pkg::sat_data(pidcu_pkg::sext_data(err)
			+ pidcu_pkg::sext_data(last_err_q));
		dmeas = pidcu_pkg::sat_data(pidcu_pkg::sext_data(sample_s1)
			- pidcu_pkg::sext_data(last_sample_q));

		p_kp = pidcu_pkg::prod_t'(kp_q) * pidcu_pkg::prod_t'(err);
		p_ig = pidcu_pkg::prod_t'(ig_q) * pidcu_pkg::prod_t'(esum);
		p_dg = pidcu_pkg::prod_t'(dg_q) * pidcu_pkg::prod_t'(dmeas);
		p_dd = pidcu_pkg::prod_t'(dd_q) * pidcu_pkg::prod_t'(deriv_q);

		integ_sum = pidcu_pkg::sext_data(integ_q) + pidcu_pkg::sext_shprod(p_ig);
		integ_sat = pidcu_pkg::sat_data(integ_sum);
		integ_new = pidcu_pkg::clamp_data(integ_sat, int_min_q, int_max_q);

		diff_sum = -pidcu_pkg::sext_shprod(p_dg) - pidcu_pkg::sext_shprod(p_dd);
		diff = pidcu_pkg::sat_data(diff_sum);

		raw_sum = pidcu_pkg::sext_shprod(p_kp) + pidcu_pkg::sext_data(integ_new)
			+ pidcu_pkg::sext_data(diff);
		raw = pidcu_pkg::clamp_data(pidcu_pkg::sat_data(raw_sum), out_min_q, out_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= pidcu_pkg::KpReset;
			ig_q <= pidcu_pkg::IntegralGainReset;
			dg_q <= pidcu_pkg::DerivGainReset;
			dd_q <= pidcu_pkg::DerivDecayReset;
			out_min_q <= pidcu_pkg::OutMinReset;
			out_max_q <= pidcu_pkg::OutMaxReset;
			int_min_q <= pidcu_pkg::IntMinReset;
			int_max_q <= pidcu_pkg::IntMaxReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pidcu_pkg::RegKp: kp_q <= cfg_data;
				pidcu_pkg::RegIntegralGain: ig_q <= cfg_data;
				pidcu_pkg::RegDerivGain: dg_q <= cfg_data;
				pidcu_pkg::RegDerivDecay: dd_q <= cfg_data;
				pidcu_pkg::RegOutMin: out_min_q <= cfg_data;
				pidcu_pkg::RegOutMax: out_max_q <= cfg_data;
				pidcu_pkg::RegIntMin: int_min_q <= cfg_data;
				pidcu_pkg::RegIntMax: int_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_err_q <= '0;
			deriv_q <= '0;
			last_sample_q <= '0;
		end else if (adv) begin
			integ_q <= integ_new;
			last_err_q <= err;
			deriv_q <= diff;
			last_sample_q <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (upd.ready) begin
				valid_s1 <= upd.valid;
			end
			if (!valid_s2 || res.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.valid && upd.ready) begin
			target_s1 <= upd.target;
			sample_s1 <= upd.sample;
		end
		if (adv) begin
			drive_s2 <= raw;
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> upd.ready)
		else $error("input not ready while stage 1 is empty");

	a_adv_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced item did not reach the output register");

	a_integ_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (int_min_q <= int_max_q) |=>
		(integ_q >= $past(int_min_q)) && (integ_q <= $past(int_max_q)))
		else $error("integrator left its limits");

	a_drive_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (out_min_q <= out_max_q) |=>
		(drive_s2 >= $past(out_min_q)) && (drive_s2 <= $past(out_max_q)))
		else $error("drive left the output limits");

endmodule

`default_nettype wire

### tb/sv/pid_controller_update_core_tb.sv
// Self-checking testbench of the PID update core: random and directed items,
// several gain and limit settings, results checked against a built-in predictor.
// Depends on pidcu_pkg, the channel interfaces and pid_controller_update_core.
`timescale 1ns / 1ps

module pid_controller_update_core_tb;

	localparam int StallLimit = 2000;
	localparam int PhaseItems = 150;
	localparam int NumPhases = 9;
	localparam int HoldCycles = 250;

	typedef struct packed {
		pidcu_pkg::data_t target;
		pidcu_pkg::data_t sample;
	} item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	pidcu_pkg::cfg_idx_t cfg_index;
	pidcu_pkg::data_t cfg_data;

	pidcu_upd_if upd_ch ();
	pidcu_res_if res_ch ();

	pid_controller_update_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.upd(upd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	item_t pending_items[$];
	pidcu_pkg::data_t expected_drive[$];
	pidcu_pkg::data_t phase_cfg[pidcu_pkg::NumRegs];

	// Predictor copy of the registers and the controller state.
	pidcu_pkg::data_t gain_regs[pidcu_pkg::NumRegs];
	pidcu_pkg::data_t integ_acc, prev_err, diff_acc, prev_sample;

	int sent_count;
	int checked_count;
	int mismatch_count;
	int settings_count;
	int rx_seen;
	int hold_left;
	bit hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pidcu_pkg::data_t clip_word(input longint v);
		pidcu_pkg::data_t r;
		if (v > longint'(pidcu_pkg::DataMax)) begin
			r = pidcu_pkg::DataMax;
		end else if (v < longint'(pidcu_pkg::DataMin)) begin
			r = pidcu_pkg::DataMin;
		end else begin
			r = pidcu_pkg::data_t'(v);
		end
		return r;
	endfunction

	// The upper bound is tested first, so inverted bounds always give one of the two.
	function automatic pidcu_pkg::data_t bound_word(input pidcu_pkg::data_t v,
			input pidcu_pkg::data_t lo, input pidcu_pkg::data_t hi);
		pidcu_pkg::data_t r;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Full product, then an arithmetic shift that floors toward minus infinity.
	function automatic longint fixed_mul(input pidcu_pkg::data_t a, input pidcu_pkg::data_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> pidcu_pkg::FracW;
	endfunction

	function automatic pidcu_pkg::data_t pid_update(input pidcu_pkg::data_t target,
			input pidcu_pkg::data_t sample);
		pidcu_pkg::data_t err, esum, integ, dmeas, diff, raw;
		err = clip_word(longint'(target) - longint'(sample));
		esum = clip_word(longint'(err) + longint'(prev_err));
		integ = clip_word(longint'(integ_acc)
			+ fixed_mul(gain_regs[pidcu_pkg::RegIntegralGain], esum));
		integ = bound_word(integ, gain_regs[pidcu_pkg::RegIntMin],
			gain_regs[pidcu_pkg::RegIntMax]);
		dmeas = clip_word(longint'(sample) - longint'(prev_sample));
		diff = clip_word(-fixed_mul(gain_regs[pidcu_pkg::RegDerivGain], dmeas)
			- fixed_mul(gain_regs[pidcu_pkg::RegDerivDecay], diff_acc));
		raw = clip_word(fixed_mul(gain_regs[pidcu_pkg::RegKp], err)
			+ longint'(integ) + longint'(diff));
		raw = bound_word(raw, gain_regs[pidcu_pkg::RegOutMin],
			gain_regs[pidcu_pkg::RegOutMax]);
		integ_acc = integ;
		diff_acc = diff;
		prev_err = err;
		prev_sample = sample;
		return raw;
	endfunction

	function automatic pidcu_pkg::data_t small_word();
		return pidcu_pkg::data_t'(longint'($urandom_range(0, 400 << 16)) - longint'(200 << 16));
	endfunction

	function automatic pidcu_pkg::data_t corner_word();
		pidcu_pkg::data_t r;
		case ($urandom_range(0, 5))
			0: r = pidcu_pkg::DataMax;
			1: r = pidcu_pkg::DataMin;
			2: r = '0;
			3: r = -32'sd1;
			4: r = 32'sd1;
			default: r = pidcu_pkg::DataMax - 32'sd1;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input pidcu_pkg::data_t got,
			input pidcu_pkg::data_t want);
		mismatch_count++;
		$display("[%0t] mismatch: %s, drive %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic push_item(input pidcu_pkg::data_t target, input pidcu_pkg::data_t sample);
		item_t it;
		it.target = target;
		it.sample = sample;
		pending_items.push_back(it);
	endtask

	// Runs of one kind: a process settling on its setpoint, full-range noise, or corners.
	task automatic queue_random_items(input int n);
		int mode;
		int run_left;
		pidcu_pkg::data_t level, meas;
		longint noise;
		run_left = 0;
		mode = 0;
		level = '0;
		meas = '0;
		for (int k = 0; k < n; k++) begin
			if (run_left == 0) begin
				mode = $urandom_range(0, 4);
				run_left = $urandom_range(5, 40);
				level = small_word();
				meas = small_word();
			end
			run_left--;
			case (mode)
				0, 1, 2: begin
					noise = longint'($urandom_range(0, 131072)) - 64'sd65536;
					meas = clip_word(longint'(meas)
						+ ((longint'(level) - longint'(meas)) >>> 3) + noise);
					push_item(level, meas);
				end
				3: push_item(pidcu_pkg::data_t'($urandom), pidcu_pkg::data_t'($urandom));
				default: push_item(corner_word(), corner_word());
			endcase
		end
	endtask

	task automatic roll_settings();
		pidcu_pkg::data_t a, b, t;
		phase_cfg[pidcu_pkg::RegKp] = ($urandom_range(0, 3) == 0)
			? pidcu_pkg::data_t'($urandom)
			: pidcu_pkg::data_t'($urandom_range(0, 50 << 16));
		phase_cfg[pidcu_pkg::RegIntegralGain] = ($urandom_range(0, 3) == 0)
			? pidcu_pkg::data_t'($urandom)
			: pidcu_pkg::data_t'($urandom_range(0, 1 << 16));
		phase_cfg[pidcu_pkg::RegDerivGain] = ($urandom_range(0, 3) == 0)
			? pidcu_pkg::data_t'($urandom)
			: pidcu_pkg::data_t'($urandom_range(0, 1 << 16));
		phase_cfg[pidcu_pkg::RegDerivDecay] = ($urandom_range(0, 3) == 0)
			? pidcu_pkg::data_t'($urandom)
			: pidcu_pkg::data_t'(longint'($urandom_range(0, 2 << 16)) - 64'sd65536);
		for (int pair = 0; pair < 2; pair++) begin
			a = ($urandom_range(0, 3) == 0) ? pidcu_pkg::data_t'($urandom) : small_word();
			b = ($urandom_range(0, 3) == 0) ? pidcu_pkg::data_t'($urandom) : small_word();
			// Mostly ordered bounds; now and then they stay inverted.
			if (a > b && $urandom_range(0, 4) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			if (pair == 0) begin
				phase_cfg[pidcu_pkg::RegOutMin] = a;
				phase_cfg[pidcu_pkg::RegOutMax] = b;
			end else begin
				phase_cfg[pidcu_pkg::RegIntMin] = a;
				phase_cfg[pidcu_pkg::RegIntMax] = b;
			end
		end
	endtask

	task automatic program_regs();
		for (int i = 0; i < pidcu_pkg::NumRegs; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= pidcu_pkg::cfg_idx_t'(i);
			cfg_data <= phase_cfg[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Waits until every item has been sent and every result has come back.
	task automatic drain();
		while (pending_items.size() != 0 || expected_drive.size() != 0 || upd_ch.valid)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Sender: holds an item until it is taken, idles at random outside a steady stretch.
	always @(posedge clk or negedge arst_n) begin
		item_t nxt;
		bit go;
		if (!arst_n) begin
			upd_ch.valid <= 1'b0;
		end else if (!upd_ch.valid || upd_ch.ready) begin
			go = pending_items.size() != 0
				&& ((sent_count >= 500 && sent_count < 800) || $urandom_range(0, 99) >= 31);
			if (go) begin
				nxt = pending_items.pop_front();
				upd_ch.target <= nxt.target;
				upd_ch.sample <= nxt.sample;
				sent_count++;
			end
			upd_ch.valid <= go;
		end
	end

	// Receiver: one long hold-off so the core backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				rx_seen++;
			if (!hold_done && rx_seen >= 300) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= (rx_seen >= 550 && rx_seen < 850) || $urandom_range(0, 99) >= 31;
			end
		end
	end

	// Predictor: tracks register writes and computes the drive of each accepted item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_regs[pidcu_pkg::RegKp] = pidcu_pkg::KpReset;
			gain_regs[pidcu_pkg::RegIntegralGain] = pidcu_pkg::IntegralGainReset;
			gain_regs[pidcu_pkg::RegDerivGain] = pidcu_pkg::DerivGainReset;
			gain_regs[pidcu_pkg::RegDerivDecay] = pidcu_pkg::DerivDecayReset;
			gain_regs[pidcu_pkg::RegOutMin] = pidcu_pkg::OutMinReset;
			gain_regs[pidcu_pkg::RegOutMax] = pidcu_pkg::OutMaxReset;
			gain_regs[pidcu_pkg::RegIntMin] = pidcu_pkg::IntMinReset;
			gain_regs[pidcu_pkg::RegIntMax] = pidcu_pkg::IntMaxReset;
			integ_acc = '0;
			prev_err = '0;
			diff_acc = '0;
			prev_sample = '0;
		end else begin
			if (cfg_we)
				gain_regs[cfg_index] = cfg_data;
			if (upd_ch.valid && upd_ch.ready)
				expected_drive.push_back(pid_update(upd_ch.target, upd_ch.sample));
		end
	end

	always @(posedge clk) begin
		pidcu_pkg::data_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_drive.size() == 0) begin
				flag_mismatch("drive with no item outstanding", res_ch.drive, '0);
			end else begin
				want = expected_drive.pop_front();
				if (res_ch.drive !== want)
					flag_mismatch("drive differs", res_ch.drive, want);
			end
			checked_count++;
		end
	end

	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < StallLimit) begin
			@(posedge clk);
			if ((upd_ch.valid && upd_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (pending_items.size() == 0 && expected_drive.size() == 0))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("[%0t] no progress for %0d cycles", $realtime, idle_run);
		$display("** pid_controller_update_core: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pidcu_pkg::RegKp;
		cfg_data = '0;
		upd_ch.valid = 1'b0;
		upd_ch.target = '0;
		upd_ch.sample = '0;
		res_ch.ready = 1'b0;
		sent_count = 0;
		checked_count = 0;
		mismatch_count = 0;
		settings_count = 1;
		rx_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gains: zero input, small steps, saturating error, its sum and
		// the measurement difference, and long runs into both clamps.
		push_item('0, '0);
		push_item(32'sd65536, '0);
		push_item(32'sd65536, '0);
		push_item(-32'sd1, '0);
		push_item('0, -32'sd1);
		push_item(pidcu_pkg::DataMax, pidcu_pkg::DataMin);
		push_item(pidcu_pkg::DataMax, pidcu_pkg::DataMin);
		push_item(pidcu_pkg::DataMin, pidcu_pkg::DataMax);
		push_item(pidcu_pkg::DataMin, pidcu_pkg::DataMax);
		push_item(pidcu_pkg::DataMax, pidcu_pkg::DataMax);
		push_item(pidcu_pkg::DataMin, pidcu_pkg::DataMin);
		push_item('0, pidcu_pkg::DataMax);
		push_item('0, pidcu_pkg::DataMin);
		for (int i = 0; i < 5; i++)
			push_item(32'sd93 <<< 16, 32'sd20 <<< 16);
		for (int i = 0; i < 5; i++)
			push_item(32'sd20 <<< 16, 32'sd93 <<< 16);
		queue_random_items(PhaseItems);

		for (int ph = 1; ph < NumPhases; ph++) begin
			drain();
			case (ph)
				1: begin
					phase_cfg[pidcu_pkg::RegKp] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegIntegralGain] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegDerivGain] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegDerivDecay] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegOutMin] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegOutMax] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegIntMin] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegIntMax] = pidcu_pkg::DataMax;
				end
				2: begin
					phase_cfg[pidcu_pkg::RegKp] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegIntegralGain] = pidcu_pkg::DataMin;
					phase_cfg[pidcu_pkg::RegDerivGain] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegDerivDecay] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegOutMin] = 32'sd10 <<< 16;
					phase_cfg[pidcu_pkg::RegOutMax] = -(32'sd10 <<< 16);
					phase_cfg[pidcu_pkg::RegIntMin] = pidcu_pkg::DataMax;
					phase_cfg[pidcu_pkg::RegIntMax] = pidcu_pkg::DataMin;
				end
				3: begin
					phase_cfg[pidcu_pkg::RegKp] = '0;
					phase_cfg[pidcu_pkg::RegIntegralGain] = '0;
					phase_cfg[pidcu_pkg::RegDerivGain] = '0;
					phase_cfg[pidcu_pkg::RegDerivDecay] = '0;
					phase_cfg[pidcu_pkg::RegOutMin] = 32'sd3 <<< 16;
					phase_cfg[pidcu_pkg::RegOutMax] = 32'sd3 <<< 16;
					phase_cfg[pidcu_pkg::RegIntMin] = '0;
					phase_cfg[pidcu_pkg::RegIntMax] = '0;
				end
				default: roll_settings();
			endcase
			program_regs();
			queue_random_items(PhaseItems);
		end
		drain();

		$display("Sent %0d items under %0d register settings; %0d results checked.",
			sent_count, settings_count, checked_count);
		$display("Settings spanned full-scale and zero gains and inverted limits; %0s",
			"the output side was held off once to back up the input.");
		if (mismatch_count == 0) begin
			$display("** pid_controller_update_core: PASSED **");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("** pid_controller_update_core: FAILED **");
		end
		$finish;
	end

endmodule
